@@ src/crc16_packet_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// crc16_packet_receiver_assert.svh
// Assertion macros shared by the packet receiver checker.
// ----------------------------------------------------------------------------
`ifndef CRC16_PACKET_RECEIVER_ASSERT_SVH
`define CRC16_PACKET_RECEIVER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packet receiver assertion failed");

// Antecedent implies consequent in the next cycle.
`define CPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packet receiver assertion failed");

`endif

@@ src/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Types, constants and the CRC-16/MODBUS byte update for the packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

   localparam logic [7:0]  HEADER_BYTE   = 8'hAA;
   localparam logic [15:0] CHECK_INIT    = 16'hFFFF;
   localparam logic [15:0] CHECK_POLY    = 16'hA001;
   localparam logic [15:0] SENSOR_RESET  = 16'd100;
   localparam logic [15:0] DISPLAY_RESET = 16'd5000;
   localparam logic [7:0]  CMD_SENSOR    = 8'd1;
   localparam logic [7:0]  CMD_DISPLAY   = 8'd2;

   typedef enum logic [2:0] {
      POS_HUNT,
      POS_CMD,
      POS_VAL_LO,
      POS_VAL_HI,
      POS_CHK_LO,
      POS_CHK_HI
   } pos_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SENSOR,
      KIND_DISPLAY
   } kind_type;

   typedef struct packed {
      logic [7:0]  packet_cmd;
      logic [15:0] packet_value;
      logic        crc_ok;
      logic [15:0] received_check;
      logic [15:0] computed_check;
      kind_type    update_kind;
      logic [15:0] sensor_period_now;
      logic [15:0] display_period_now;
   } result_type;

   // Bitwise reflected CRC update for one byte, eight shift steps.
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CHECK_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/cpr_frame.sv @@
// ----------------------------------------------------------------------------
// cpr_frame
// Header hunt, byte collection, running CRC and period registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_frame (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           rx_byte,
   output logic                      at_last,
   output logic                      emit,
   output cpr_pkg::result_type       result
);

   cpr_pkg::pos_type pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] value_ff, value_in;
   logic [7:0]  chk_lo_ff, chk_lo_in;
   logic [15:0] sensor_ff, sensor_in;
   logic [15:0] display_ff, display_in;

   logic [15:0] crc_next;
   logic [15:0] rx_check;
   logic        ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= cpr_pkg::POS_HUNT;
         crc_ff     <= cpr_pkg::CHECK_INIT;
         cmd_ff     <= '0;
         value_ff   <= '0;
         chk_lo_ff  <= '0;
         sensor_ff  <= cpr_pkg::SENSOR_RESET;
         display_ff <= cpr_pkg::DISPLAY_RESET;
      end else if (accept) begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         cmd_ff     <= cmd_in;
         value_ff   <= value_in;
         chk_lo_ff  <= chk_lo_in;
         sensor_ff  <= sensor_in;
         display_ff <= display_in;
      end
   end

   assign at_last  = (pos_ff == cpr_pkg::POS_CHK_HI);
   assign crc_next = cpr_pkg::crc_update(
      (pos_ff == cpr_pkg::POS_HUNT) ? cpr_pkg::CHECK_INIT : crc_ff, rx_byte);
   assign rx_check = {rx_byte, chk_lo_ff};
   assign ok       = (rx_check == crc_ff);

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      chk_lo_in  = chk_lo_ff;
      sensor_in  = sensor_ff;
      display_in = display_ff;
      emit       = 1'b0;
      result.packet_cmd     = cmd_ff;
      result.packet_value   = value_ff;
      result.crc_ok         = ok;
      result.received_check = rx_check;
      result.computed_check = crc_ff;
      result.update_kind    = cpr_pkg::KIND_NONE;
      case (pos_ff)
         cpr_pkg::POS_HUNT: begin
            if (rx_byte == cpr_pkg::HEADER_BYTE) begin
               crc_in = crc_next;
               pos_in = cpr_pkg::POS_CMD;
            end else begin
               crc_in = cpr_pkg::CHECK_INIT;
            end
         end
         cpr_pkg::POS_CMD: begin
            cmd_in = rx_byte;
            crc_in = crc_next;
            pos_in = cpr_pkg::POS_VAL_LO;
         end
         cpr_pkg::POS_VAL_LO: begin
            value_in = {8'h00, rx_byte};
            crc_in   = crc_next;
            pos_in   = cpr_pkg::POS_VAL_HI;
         end
         cpr_pkg::POS_VAL_HI: begin
            value_in = {rx_byte, value_ff[7:0]};
            crc_in   = crc_next;
            pos_in   = cpr_pkg::POS_CHK_LO;
         end
         cpr_pkg::POS_CHK_LO: begin
            chk_lo_in = rx_byte;
            pos_in    = cpr_pkg::POS_CHK_HI;
         end
         cpr_pkg::POS_CHK_HI: begin
            emit   = accept;
            pos_in = cpr_pkg::POS_HUNT;
            crc_in = cpr_pkg::CHECK_INIT;
            if (ok && cmd_ff == cpr_pkg::CMD_SENSOR) begin
               sensor_in          = value_ff;
               result.update_kind = cpr_pkg::KIND_SENSOR;
            end else if (ok && cmd_ff == cpr_pkg::CMD_DISPLAY) begin
               display_in         = value_ff;
               result.update_kind = cpr_pkg::KIND_DISPLAY;
            end
         end
         default: begin
            pos_in = cpr_pkg::POS_HUNT;
            crc_in = cpr_pkg::CHECK_INIT;
         end
      endcase
      result.sensor_period_now  = sensor_in;
      result.display_period_now = display_in;
   end

endmodule

`default_nettype wire

@@ src/cpr_out.sv @@
// ----------------------------------------------------------------------------
// cpr_out
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire cpr_pkg::result_type  result_in,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic                      busy,
   output cpr_pkg::result_type       result_out
);

   logic                valid_ff;
   cpr_pkg::result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign busy       = valid_ff && rsp_stall;
   assign result_out = data_ff;

endmodule

`default_nettype wire

@@ src/crc16_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// crc16_packet_receiver
// Framed packet receiver with CRC-16/MODBUS check and period update.
// ----------------------------------------------------------------------------
// Takes one received byte per clock. Bytes are dropped until the 0xAA header;
// then command, value (little-endian) and check (little-endian) follow, and
// the sixth byte yields one result word, registered and shown on the cycle
// after that byte is taken. A good packet with command 1 or 2 loads the
// sensor or display period. Throughput is one byte per cycle, set by the
// single-byte CRC network that feeds back into the frame CRC register; the
// only hold-off is on a packet's last byte while the previous result word
// still sits stalled in the result register.
`default_nettype none

module crc16_packet_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_packet_cmd,
   output logic [15:0]      rsp_packet_value,
   output logic             rsp_crc_ok,
   output logic [15:0]      rsp_received_check,
   output logic [15:0]      rsp_computed_check,
   output logic [1:0]       rsp_update_kind,
   output logic [15:0]      rsp_sensor_period_now,
   output logic [15:0]      rsp_display_period_now
);

   logic                accept;
   logic                at_last;
   logic                emit;
   logic                busy;
   cpr_pkg::result_type result;
   cpr_pkg::result_type result_q;

   assign req_stall = at_last && busy;
   assign accept    = req_valid && !req_stall;

   cpr_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .at_last (at_last),
      .emit    (emit),
      .result  (result)
   );

   cpr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .result_in  (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .busy       (busy),
      .result_out (result_q)
   );

   assign rsp_packet_cmd         = result_q.packet_cmd;
   assign rsp_packet_value       = result_q.packet_value;
   assign rsp_crc_ok             = result_q.crc_ok;
   assign rsp_received_check     = result_q.received_check;
   assign rsp_computed_check     = result_q.computed_check;
   assign rsp_update_kind        = result_q.update_kind;
   assign rsp_sensor_period_now  = result_q.sensor_period_now;
   assign rsp_display_period_now = result_q.display_period_now;

endmodule

`default_nettype wire

@@ src/cpr_checker.sv @@
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks for the packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_packet_receiver_assert.svh"

module cpr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_packet_cmd,
   input wire logic [15:0] rsp_packet_value,
   input wire logic        rsp_crc_ok,
   input wire logic [15:0] rsp_received_check,
   input wire logic [15:0] rsp_computed_check,
   input wire logic [1:0]  rsp_update_kind,
   input wire logic [15:0] rsp_sensor_period_now,
   input wire logic [15:0] rsp_display_period_now
);

   logic        update_seen;
   logic        sensor_seen;
   logic        ok_consistent;
   logic        sensor_consistent;
   logic        rsp_held;
   logic [90:0] rsp_word;

   assign update_seen       = rsp_valid && (rsp_update_kind != cpr_pkg::KIND_NONE);
   assign sensor_seen       = rsp_valid && (rsp_update_kind == cpr_pkg::KIND_SENSOR);
   assign ok_consistent     = rsp_crc_ok == (rsp_received_check == rsp_computed_check);
   assign sensor_consistent = (rsp_sensor_period_now == rsp_packet_value)
                              && (rsp_packet_cmd == cpr_pkg::CMD_SENSOR);
   assign rsp_held          = rsp_valid && rsp_stall;
   assign rsp_word          = {rsp_packet_cmd, rsp_packet_value, rsp_crc_ok,
                               rsp_received_check, rsp_computed_check, rsp_update_kind,
                               rsp_sensor_period_now, rsp_display_period_now};

   `CPR_ASSERT_IMPLY(a_ok_matches, clock, reset, rsp_valid, ok_consistent)
   `CPR_ASSERT_IMPLY(a_update_needs_ok, clock, reset, update_seen, rsp_crc_ok)
   `CPR_ASSERT_IMPLY(a_sensor_loaded, clock, reset, sensor_seen, sensor_consistent)
   `CPR_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_held)
   `CPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))

endmodule

bind crc16_packet_receiver cpr_checker u_cpr_checker (.*);

`default_nettype wire
